// ----- design/multi_polygon_containment_assert.svh -----
// Assertion shorthands used by the checker file.
`ifndef MULTI_POLYGON_CONTAINMENT_ASSERT_SVH
`define MULTI_POLYGON_CONTAINMENT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define MPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define MPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/mpc_pkg.sv -----
package mpc_pkg;

    localparam int HIT_W = 4;

    // Polygons below this vertex count never hold a point.
    localparam logic [1:0] MIN_POLY_VERTS = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic vld;
        logic last;
        logic ok;
    } t_edge_ctl;

    typedef struct packed {
        logic busy;
        logic found;
    } t_edge_stat;

endpackage

// ----- design/mpc_cell.sv -----
module mpc_cell #(
    parameter int CW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic                 i_cls,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic                 o_cls
);

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic                 r_cls;

    // Take the neighbor's vertex on every shift, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_cls <= i_cls;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_cls = r_cls;

endmodule

// ----- design/mpc_edge.sv -----
module mpc_edge #(
    parameter int CW  = 24,
    parameter int HIW = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  mpc_pkg::t_edge_ctl    i_ctl,
    input  logic signed [CW-1:0]  i_xi,
    input  logic signed [CW-1:0]  i_yi,
    input  logic signed [CW-1:0]  i_xj,
    input  logic signed [CW-1:0]  i_yj,
    input  logic signed [CW-1:0]  i_px,
    input  logic signed [CW-1:0]  i_py,
    output mpc_pkg::t_edge_stat   o_stat,
    output logic [HIW-1:0]        o_hit
);

    import mpc_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    t_edge_ctl            r1_ctl;
    logic                 r1_str;
    logic signed [DW-1:0] r1_dy;
    logic signed [DW-1:0] r1_a;
    logic signed [DW-1:0] r1_c;
    logic signed [DW-1:0] r1_d;

    t_edge_ctl            r2_ctl;
    logic                 r2_str;
    logic                 r2_dypos;
    logic                 r2_dyneg;
    logic signed [PW-1:0] r2_p1;
    logic signed [PW-1:0] r2_p2;

    logic                 r_par;
    logic                 r_found;
    logic [HIW-1:0]       r_pidx;
    logic [HIW-1:0]       r_hit;

    logic signed [PW-1:0] w_p1;
    logic signed [PW-1:0] w_p2;
    logic                 w_cross;
    logic                 w_par;

    // Stage 1: differences and straddle test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_str <= (i_yi > i_py) != (i_yj > i_py);
        r1_dy  <= DW'(i_yj) - DW'(i_yi);
        r1_a   <= DW'(i_px) - DW'(i_xi);
        r1_c   <= DW'(i_xj) - DW'(i_xi);
        r1_d   <= DW'(i_py) - DW'(i_yi);
    end

    // Stage 2: cross-multiplied sides of the crossing inequality.
    assign w_p1 = r1_a * r1_dy;
    assign w_p2 = r1_c * r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_str   <= r1_str;
        r2_dypos <= r1_dy > 0;
        r2_dyneg <= r1_dy[DW-1];
        r2_p1    <= w_p1;
        r2_p2    <= w_p2;
    end

    // Stage 3: toggle parity, commit it at the closing edge of each polygon.
    assign w_cross = r2_str && ((r2_dypos && (r2_p1 < r2_p2)) ||
                                (r2_dyneg && (r2_p1 > r2_p2)));
    assign w_par   = r_par ^ w_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_par   <= 1'b0;
            r_found <= 1'b0;
            r_pidx  <= '0;
            r_hit   <= '0;
        end else if (r2_ctl.vld) begin
            if (r2_ctl.last) begin
                if (r2_ctl.ok && w_par && !r_found) begin
                    r_found <= 1'b1;
                    r_hit   <= r_pidx;
                end
                r_pidx <= r_pidx + HIW'(1);
                r_par  <= 1'b0;
            end else begin
                r_par <= w_par;
            end
        end
    end

    assign o_stat.busy  = r1_ctl.vld || r2_ctl.vld;
    assign o_stat.found = r_found;
    assign o_hit        = r_hit;

endmodule

// ----- design/multi_polygon_containment.sv -----
// Multi-polygon containment.
// Input channel (i_in_valid / o_in_stall) takes one item: a command with a
// coordinate pair and a close flag. Output channel (o_out_valid / i_out_stall)
// returns exactly one result item per input item, in order.
// Clear and append finish when taken; the result sits in the output
// register the cycle after the item is taken. An append into a full store
// (all vertex cells used, or all polygons closed) is refused with store_error.
// A query rotates the whole vertex chain once, one cell per cycle in scan,
// with a close step for the closing edge of each closed polygon, then waits
// in drain for the crossing pipeline to empty and the output register to be
// free before its result is loaded; the next item is taken after that.
// Reset empties the store (vertex and polygon counts to zero) and the output
// register. A stalled result holds in the output register; the block still
// takes the next item while the register drains in the same cycle, and a
// finished query waits in drain until the register is free.
module multi_polygon_containment #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_POLYGONS = 16,
    parameter int COORD_BITS   = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic                          i_closes_polygon,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_any,
    output logic [mpc_pkg::HIT_W-1:0]     o_hit_polygon,
    output logic                          o_store_error
);

    import mpc_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int PCW = $clog2(MAX_POLYGONS + 1);
    localparam int HIW = ($clog2(MAX_POLYGONS) > HIT_W) ? $clog2(MAX_POLYGONS) : HIT_W;
    localparam int CW  = COORD_BITS;

    // Vertex chain: cell 0 is the head, the last cell feeds back on rotation.
    logic signed [CW-1:0] w_dx  [MAX_VERTICES];
    logic signed [CW-1:0] w_dy  [MAX_VERTICES];
    logic                 w_dcl [MAX_VERTICES];
    logic signed [CW-1:0] w_cx  [MAX_VERTICES];
    logic signed [CW-1:0] w_cy  [MAX_VERTICES];
    logic                 w_ccl [MAX_VERTICES];

    t_state               r_state;
    t_state               n_state;
    logic [VCW-1:0]       r_vcount;
    logic [PCW-1:0]       r_pcount;
    logic [VCW-1:0]       r_rot;
    logic [1:0]           r_pcnt;
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic signed [CW-1:0] r_first_x;
    logic signed [CW-1:0] r_first_y;
    logic signed [CW-1:0] r_prev_x;
    logic signed [CW-1:0] r_prev_y;

    logic                 r_ovalid;
    logic                 r_inside;
    logic [HIT_W-1:0]     r_hit;
    logic                 r_err;

    logic                 w_slot_free;
    logic                 w_ready;
    logic                 w_acc_in;
    logic                 w_full;
    logic                 w_tail_live;
    logic                 w_tail_cls;
    logic                 w_last_shift;
    logic                 w_rot_done;
    logic                 w_shift;
    logic                 w_head_new;
    logic                 w_append;
    logic                 w_clear;
    logic                 w_start;
    logic                 w_take;
    logic                 w_close;
    logic                 w_load;
    logic                 w_qres;
    logic                 w_err;

    t_edge_ctl            w_ectl;
    t_edge_stat           w_estat;
    logic signed [CW-1:0] w_exi;
    logic signed [CW-1:0] w_eyi;
    logic [HIW-1:0]       w_hit;

    assign w_dx[0]  = w_head_new ? i_pos_x : w_cx[MAX_VERTICES-1];
    assign w_dy[0]  = w_head_new ? i_pos_y : w_cy[MAX_VERTICES-1];
    assign w_dcl[0] = w_head_new ? i_closes_polygon : w_ccl[MAX_VERTICES-1];

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_chain
        if (g > 0) begin : g_link
            assign w_dx[g]  = w_cx[g-1];
            assign w_dy[g]  = w_cy[g-1];
            assign w_dcl[g] = w_ccl[g-1];
        end
        mpc_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_x     (w_dx[g]),
            .i_y     (w_dy[g]),
            .i_cls   (w_dcl[g]),
            .o_x     (w_cx[g]),
            .o_y     (w_cy[g]),
            .o_cls   (w_ccl[g])
        );
    end

    // After n appends vertex 0 sits in cell n-1; the tail first emits the
    // MAX_VERTICES - n stale cells, then vertices 0 .. n-1 in order.
    assign w_tail_live  = ({1'b0, r_rot} + {1'b0, r_vcount}) >= (VCW + 1)'(MAX_VERTICES);
    assign w_tail_cls   = w_ccl[MAX_VERTICES-1];
    assign w_last_shift = r_rot == VCW'(MAX_VERTICES - 1);
    assign w_rot_done   = r_rot == VCW'(MAX_VERTICES);
    assign w_full       = (r_vcount == VCW'(MAX_VERTICES)) ||
                          (r_pcount == PCW'(MAX_POLYGONS));
    assign w_slot_free  = !r_ovalid || !i_out_stall;
    assign w_acc_in     = i_in_valid && w_ready;
    assign o_in_stall   = !w_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in && (i_command == CMD_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tail_live && w_tail_cls) begin
                    n_state = ST_CLOSE;
                end else if (w_last_shift) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_CLOSE: begin
                n_state = w_rot_done ? ST_DRAIN : ST_SCAN;
            end
            ST_DRAIN: begin
                if (!w_estat.busy && w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        w_ready    = 1'b0;
        w_shift    = 1'b0;
        w_head_new = 1'b0;
        w_append   = 1'b0;
        w_clear    = 1'b0;
        w_start    = 1'b0;
        w_take     = 1'b0;
        w_close    = 1'b0;
        w_load     = 1'b0;
        w_qres     = 1'b0;
        w_err      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = w_slot_free;
                if (w_acc_in) begin
                    case (i_command)
                        CMD_CLEAR: begin
                            w_clear = 1'b1;
                            w_load  = 1'b1;
                        end
                        CMD_APPEND: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_err = 1'b1;
                            end else begin
                                w_append   = 1'b1;
                                w_shift    = 1'b1;
                                w_head_new = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            w_start = 1'b1;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_shift = 1'b1;
                w_take  = w_tail_live;
            end
            ST_CLOSE: begin
                w_close = 1'b1;
            end
            ST_DRAIN: begin
                if (!w_estat.busy && w_slot_free) begin
                    w_load = 1'b1;
                    w_qres = 1'b1;
                end
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    // Edge to test: a live vertex against its predecessor, or on close the
    // first vertex of the polygon against its last.
    assign w_ectl.vld  = (w_take && (r_pcnt != 2'd0)) || w_close;
    assign w_ectl.last = w_close;
    assign w_ectl.ok   = w_close && (r_pcnt == MIN_POLY_VERTS);
    assign w_exi       = w_close ? r_first_x : w_cx[MAX_VERTICES-1];
    assign w_eyi       = w_close ? r_first_y : w_cy[MAX_VERTICES-1];

    mpc_edge #(
        .CW  (CW),
        .HIW (HIW)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ctl   (w_ectl),
        .i_xi    (w_exi),
        .i_yi    (w_eyi),
        .i_xj    (r_prev_x),
        .i_yj    (r_prev_y),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_stat  (w_estat),
        .o_hit   (w_hit)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vcount <= '0;
            r_pcount <= '0;
            r_rot    <= '0;
            r_pcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_vcount <= '0;
                r_pcount <= '0;
            end else if (w_append) begin
                r_vcount <= r_vcount + VCW'(1);
                if (i_closes_polygon) begin
                    r_pcount <= r_pcount + PCW'(1);
                end
            end
            if (w_start) begin
                r_rot  <= '0;
                r_pcnt <= '0;
            end else begin
                if (w_shift && !w_head_new) begin
                    r_rot <= r_rot + VCW'(1);
                end
                if (w_close) begin
                    r_pcnt <= '0;
                end else if (w_take) begin
                    // Saturate: only "three or more" matters.
                    r_pcnt <= (r_pcnt == MIN_POLY_VERTS) ? r_pcnt : r_pcnt + 2'd1;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Query point, polygon walk and result payload.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (w_take) begin
            r_prev_x <= w_cx[MAX_VERTICES-1];
            r_prev_y <= w_cy[MAX_VERTICES-1];
            if (r_pcnt == 2'd0) begin
                r_first_x <= w_cx[MAX_VERTICES-1];
                r_first_y <= w_cy[MAX_VERTICES-1];
            end
        end
        if (w_load) begin
            r_inside <= w_qres && w_estat.found;
            r_hit    <= w_qres ? w_hit[HIT_W-1:0] : '0;
            r_err    <= w_err;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_inside_any  = r_inside;
    assign o_hit_polygon = r_hit;
    assign o_store_error = r_err;

endmodule

// ----- design/mpc_checker.sv -----
`include "multi_polygon_containment_assert.svh"

module mpc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [1:0]                i_command,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_inside_any,
    input logic [mpc_pkg::HIT_W-1:0] o_hit_polygon,
    input logic                      o_store_error
);

    import mpc_pkg::*;

    // Hold a stalled result and its payload.
    `MPC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `MPC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_inside_any) && $stable(o_hit_polygon) && $stable(o_store_error))

    // A query hit and a refused append never share one result.
    `MPC_ASSERT_NOW(a_excl, o_out_valid, !(o_inside_any && o_store_error))

    // Without a hit the polygon index reads zero.
    `MPC_ASSERT_NOW(a_hit_zero, o_out_valid && !o_inside_any, o_hit_polygon == '0)

    // A taken query occupies the block on the following cycle.
    `MPC_ASSERT_NEXT(a_query_busy, i_in_valid && !o_in_stall && (i_command == CMD_QUERY), o_in_stall)

endmodule

bind multi_polygon_containment mpc_checker u_mpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_inside_any  (o_inside_any),
    .o_hit_polygon (o_hit_polygon),
    .o_store_error (o_store_error)
);
